[hw/rtl/sfc_pkg.sv]
// shared constants, field widths and codes of the streaming fir convolver
// depends on nothing; used by the channel interfaces and the top level
package sfc_pkg;

    localparam int TAPS_DEFAULT = 1024;

    localparam int OPCODE_W   = 2;
    localparam int TAP_W      = 10;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int IR_LEN_W   = 11;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_COEF  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] REG_IR_LENGTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SHIFT = 1'd1;

    localparam logic [IR_LEN_W-1:0] IR_LENGTH_RESET    = 11'd1;
    localparam logic [SHIFT_W-1:0]  OUTPUT_SHIFT_RESET = 5'd15;

    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

endpackage

[hw/rtl/sfc_if.sv]
// valid/ready channel interfaces: command beats in, filtered sample beats out
// depends on sfc_pkg for the field widths
interface sfc_in_if;
    import sfc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [TAP_W-1:0]           tap_index;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output opcode, output tap_index, output sample_value,
                    input ready);
    modport sink   (input valid, input opcode, input tap_index, input sample_value,
                    output ready);
endinterface

interface sfc_out_if;
    import sfc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       saturated;

    modport source (output valid, output out_sample, output saturated, input ready);
    modport sink   (input valid, input out_sample, input saturated, output ready);
endinterface

[hw/rtl/streaming_fir_convolver.sv]
// streaming fir convolver top level: sequencer, mac datapath, round and saturate
// depends on sfc_pkg, sfc_if (sfc_in_if, sfc_out_if) and sfc_ram
//
//  channel | dir | beat fields                          | handshake
//  --------+-----+--------------------------------------+-------------------
//  item    | in  | opcode, tap_index, sample_value      | valid/ready
//  result  | out | out_sample, saturated                | valid/ready
//  cfg     | in  | cfg_index, cfg_data                  | cfg_we, no stall
//
// a push beat uses n taps, n = min(ir_length, TAPS, samples since clear),
// and skips the tap loop when n is zero:
// one read of both rams per tap, then multiply, accumulate, round and saturate.
// coefficient write and clear beats do not leave the idle state.
// after reset the coefficient ram is swept to zero with item.ready low.
// the result register holds a beat while result.ready is low; item beats are
// still taken and a following push waits at its final stage for the slot.
module streaming_fir_convolver #(
    parameter int TAPS = sfc_pkg::TAPS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfc_pkg::CFG_DATA_W-1:0] cfg_data,
    sfc_in_if.sink                item,
    sfc_out_if.source             result
);
    import sfc_pkg::*;

    localparam int AW    = $clog2(TAPS);              // ram address width
    localparam int CW    = AW + 1;                    // counts up to TAPS
    localparam int ACC_W = PROD_W + AW;               // exact sum of TAPS products
    localparam int TW    = (AW > TAP_W) ? AW : TAP_W;
    localparam int NW    = (CW > IR_LEN_W) ? CW : IR_LEN_W;

    typedef enum logic [4:0] {
        S_SWEEP = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MAC   = 5'b00100,
        S_ROUND = 5'b01000,
        S_SAT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [IR_LEN_W-1:0] ir_len_reg;
    logic [SHIFT_W-1:0]  shift_reg;

    // history bookkeeping: the fill count stands in for zeroing the history ram
    logic [AW-1:0] newest_reg, newest_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] sweep_addr_reg, sweep_addr_next;

    // tap loop
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] k_reg, k_next;
    logic [AW-1:0] slot_reg, slot_next;

    // mac pipeline
    logic                     rd_vld_reg, rd_last_reg;
    logic                     prod_vld_reg, prod_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  sum_reg;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_sat_reg;

    // ram ports
    logic                coef_we, hist_we;
    logic [AW-1:0]       coef_waddr;
    logic [SAMPLE_W-1:0] coef_wdata;
    logic [SAMPLE_W-1:0] coef_q, hist_q;

    logic          accept;
    logic          issue;
    logic          load_out;
    logic [TW:0]   tap_ext;
    logic          tap_ok;
    logic [AW-1:0] next_slot;
    logic [CW-1:0] fill_inc;
    logic [NW-1:0] lim_taps, lim_fill;

    logic [ACC_W-1:0]        round_const;
    logic signed [ACC_W-1:0] shifted;
    logic signed [SAMPLE_W-1:0] sat_value;
    logic                    sat_flag;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;

    assign tap_ext = (TW + 1)'(item.tap_index);
    assign tap_ok  = tap_ext < (TW + 1)'(TAPS);

    assign next_slot = (newest_reg == AW'(TAPS - 1)) ? '0 : newest_reg + 1'b1;
    assign fill_inc  = (fill_reg == CW'(TAPS)) ? fill_reg : fill_reg + 1'b1;

    // taps in use: ir_length, capped by the depth and by samples since clear
    assign lim_taps = (NW'(ir_len_reg) < NW'(TAPS)) ? NW'(ir_len_reg) : NW'(TAPS);
    assign lim_fill = (lim_taps < NW'(fill_inc)) ? lim_taps : NW'(fill_inc);

    assign issue = (state_reg == S_MAC) && (k_reg != n_reg);

    // round half up, then arithmetic shift and clip
    assign round_const = (shift_reg == '0) ? '0 : (ACC_W'(1) << (shift_reg - 1'b1));
    assign shifted     = sum_reg >>> shift_reg;

    always_comb
    begin
        sat_flag  = 1'b0;
        sat_value = shifted[SAMPLE_W-1:0];
        if (shifted > $signed(ACC_W'(SAT_MAX)))
        begin
            sat_flag  = 1'b1;
            sat_value = SAMPLE_W'(SAT_MAX);
        end
        else if (shifted < $signed(ACC_W'(SAT_MIN)))
        begin
            sat_flag  = 1'b1;
            sat_value = SAMPLE_W'(SAT_MIN);
        end
    end

    assign load_out = (state_reg == S_SAT) && (!out_valid_reg || result.ready);

    // ram write side: reset sweep or coefficient beat, push beat into history
    always_comb
    begin
        coef_we    = 1'b0;
        coef_waddr = tap_ext[AW-1:0];
        coef_wdata = item.sample_value;
        if (state_reg == S_SWEEP)
        begin
            coef_we    = 1'b1;
            coef_waddr = sweep_addr_reg;
            coef_wdata = '0;
        end
        else if (accept && item.opcode == OP_COEF && tap_ok)
        begin
            coef_we = 1'b1;
        end
    end

    assign hist_we = accept && (item.opcode == OP_PUSH);

    sfc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (k_reg[AW-1:0]),
        .rdata (coef_q)
    );

    // the pushed sample is written in the accept cycle, its first read is issued in the cycle after
    sfc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (next_slot),
        .wdata (item.sample_value),
        .raddr (slot_reg),
        .rdata (hist_q)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        newest_next     = newest_reg;
        fill_next       = fill_reg;
        sweep_addr_next = sweep_addr_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        slot_next       = slot_reg;
        acc_next        = acc_reg;

        unique case (state_reg)
            S_SWEEP:
            begin
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == AW'(TAPS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.opcode)
                        OP_PUSH:
                        begin
                            newest_next = next_slot;
                            fill_next   = fill_inc;
                            n_next      = CW'(lim_fill);
                            k_next      = '0;
                            slot_next   = next_slot;
                            acc_next    = '0;
                            state_next  = (lim_fill == '0) ? S_ROUND : S_MAC;
                        end
                        OP_CLEAR:
                        begin
                            newest_next = '0;
                            fill_next   = '0;
                        end
                        default:
                        begin
                            // coefficient beats only touch the ram, opcode 3 is dropped
                        end
                    endcase
                end
            end
            S_MAC:
            begin
                if (issue)
                begin
                    k_next    = k_reg + 1'b1;
                    slot_next = (slot_reg == '0) ? AW'(TAPS - 1) : slot_reg - 1'b1;
                end
                if (prod_vld_reg)
                begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                    if (prod_last_reg)
                    begin
                        state_next = S_ROUND;
                    end
                end
            end
            S_ROUND:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            ir_len_reg     <= IR_LENGTH_RESET;
            shift_reg      <= OUTPUT_SHIFT_RESET;
            newest_reg     <= '0;
            fill_reg       <= '0;
            sweep_addr_reg <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            slot_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
            prod_vld_reg   <= 1'b0;
            prod_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            newest_reg     <= newest_next;
            fill_reg       <= fill_next;
            sweep_addr_reg <= sweep_addr_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            slot_reg       <= slot_next;
            rd_vld_reg     <= issue;
            rd_last_reg    <= issue && (k_reg == n_reg - 1'b1);
            prod_vld_reg   <= rd_vld_reg;
            prod_last_reg  <= rd_last_reg;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IR_LENGTH:    ir_len_reg <= cfg_data[IR_LEN_W-1:0];
                    REG_OUTPUT_SHIFT: shift_reg  <= cfg_data[SHIFT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(coef_q) * $signed(hist_q);
        acc_reg  <= acc_next;
        if (state_reg == S_ROUND)
        begin
            sum_reg <= acc_reg + $signed(round_const);
        end
        if (load_out)
        begin
            out_sample_reg <= sat_value;
            out_sat_reg    <= sat_flag;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_sample = out_sample_reg;
    assign result.saturated  = out_sat_reg;

endmodule

[hw/rtl/sfc_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module sfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
